// ----- sv/aws_pkg.sv -----
`default_nettype none
package aws_pkg;
    localparam int unsigned MaxItems = 16;
    localparam int unsigned WordW = 32;
    typedef logic [WordW-1:0] t_word;
endpackage
`default_nettype wire

// ----- sv/aws_front.sv -----
`default_nettype none
// Collects one set into the store; on the closing item, hands the set to the back end.
module aws_front #(
    parameter int unsigned MAX_ITEMS = aws_pkg::MaxItems,
    localparam int unsigned IdxW = $clog2(MAX_ITEMS),
    localparam int unsigned CntW = $clog2(MAX_ITEMS + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire aws_pkg::t_word   i_word,
    input  wire logic             i_last,
    output logic                  o_we,
    output logic [IdxW-1:0]       o_waddr,
    output aws_pkg::t_word        o_wdata,
    output logic                  o_done,
    output logic [CntW-1:0]       o_count,
    input  wire logic             i_back_busy
);
    logic [CntW-1:0] r_cnt;
    logic            fire;
    logic [CntW-1:0] n_cnt;

    assign o_ready = !i_back_busy;
    assign fire    = i_valid && o_ready;
    assign n_cnt   = r_cnt + CntW'(1);
    assign o_we    = fire;
    assign o_waddr = r_cnt[IdxW-1:0];
    assign o_wdata = i_word;
    assign o_done  = fire && (i_last || n_cnt == CntW'(MAX_ITEMS));
    assign o_count = n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (fire) begin
            r_cnt <= o_done ? '0 : n_cnt;
        end
    end
endmodule
`default_nettype wire

// ----- sv/aws_back.sv -----
`default_nettype none
// Selection sort over the store: each pass scans for the minimum, swaps it forward, emits it.
module aws_back #(
    parameter int unsigned MAX_ITEMS = aws_pkg::MaxItems,
    localparam int unsigned IdxW = $clog2(MAX_ITEMS),
    localparam int unsigned CntW = $clog2(MAX_ITEMS + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_we,
    input  wire logic [IdxW-1:0]  i_waddr,
    input  wire aws_pkg::t_word   i_wdata,
    input  wire logic             i_start,
    input  wire logic [CntW-1:0]  i_count,
    output logic                  o_busy,
    output logic                  o_tvalid,
    input  wire logic             i_tready,
    output aws_pkg::t_word        o_word,
    output logic                  o_last
);
    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SWAP, S_OUT} t_state;

    aws_pkg::t_word  r_mem [MAX_ITEMS];
    t_state          r_state;
    logic [CntW-1:0] r_n, r_base, r_scan;
    logic [IdxW-1:0] r_minidx;
    aws_pkg::t_word  r_min, r_word;
    logic            r_last, r_valid;
    aws_pkg::t_word  rd;

    assign rd       = r_mem[r_scan[IdxW-1:0]];
    assign o_busy   = (r_state != S_IDLE) || r_valid;
    assign o_tvalid = r_valid;
    assign o_word   = r_word;
    assign o_last   = r_last;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        else if (r_state == S_SWAP) begin
            if (r_minidx != r_base[IdxW-1:0]) r_mem[r_minidx] <= r_mem[r_base[IdxW-1:0]];
            r_mem[r_base[IdxW-1:0]] <= r_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_tready && (r_state != S_OUT)) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_start) begin
                    r_n     <= i_count;
                    r_base  <= '0;
                    r_scan  <= '0;
                    r_min   <= '1;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_scan == r_base || rd < r_min) begin
                        r_min    <= rd;
                        r_minidx <= r_scan[IdxW-1:0];
                    end
                    if (r_scan + CntW'(1) == r_n) r_state <= S_SWAP;
                    else r_scan <= r_scan + CntW'(1);
                end
                S_SWAP: r_state <= S_OUT;
                S_OUT: if (!r_valid || i_tready) begin
                    r_valid <= 1'b1;
                    r_word  <= r_min;
                    r_last  <= (r_base + CntW'(1) == r_n);
                    if (r_base + CntW'(1) == r_n) r_state <= S_IDLE;
                    else begin
                        r_base  <= r_base + CntW'(1);
                        r_scan  <= r_base + CntW'(1);
                        r_state <= S_SCAN;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- sv/ascending_word_sorter_top.sv -----
`default_nettype none
// Sorts a set of up to MAX_ITEMS 32-bit unsigned words into ascending order. Words are taken
// one per cycle while loading; the set closes on tlast or when the store fills. Each output
// word then takes a selection scan over the single store read port; input stalls until the
// last sorted word is taken.
module ascending_word_sorter_top #(
    parameter int unsigned MAX_ITEMS = aws_pkg::MaxItems
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // word_in
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // word_out
    output logic             m_axis_tlast
);
    localparam int unsigned IdxW = $clog2(MAX_ITEMS);
    localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);
    logic            we, done, busy;
    logic [IdxW-1:0] waddr;
    aws_pkg::t_word  wdata;
    logic [CntW-1:0] cnt;

    aws_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_word(s_axis_tdata), .i_last(s_axis_tlast), .o_we(we), .o_waddr(waddr),
        .o_wdata(wdata), .o_done(done), .o_count(cnt), .i_back_busy(busy)
    );
    aws_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
        .i_clk, .i_rst_n, .i_we(we), .i_waddr(waddr), .i_wdata(wdata), .i_start(done),
        .i_count(cnt), .o_busy(busy), .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready),
        .o_word(m_axis_tdata), .o_last(m_axis_tlast)
    );
endmodule
`default_nettype wire
